FILE: hw/rtl/lcgx_pkg.sv
// shared types and constants for the lcg keystream xor cipher
package lcgx_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_PASS  = 2'd1,
        OP_SALT  = 2'd2,
        OP_DATA  = 2'd3
    } op_t;

    localparam int unsigned STATE_W = 31;

    localparam logic [STATE_W-1:0] LCG_SEED = 31'h12345678;
    localparam logic [STATE_W-1:0] LCG_MUL  = 31'd1103515245;
    localparam logic [STATE_W-1:0] LCG_ADD  = 31'd12345;

    typedef struct packed {
        logic [STATE_W-1:0] lcg_state;
        logic               key_seen;
        logic               has_result;
        logic [7:0]         byte_out;
    } step_t;

endpackage

FILE: hw/rtl/lcgx_step.sv
// next-state and keystream logic for one request
module lcgx_step (
    input  lcgx_pkg::op_t                    op,
    input  logic [7:0]                       byte_in,
    input  logic [lcgx_pkg::STATE_W-1:0]     lcg_state,
    input  logic                             key_seen,
    output lcgx_pkg::step_t                  step
);
    import lcgx_pkg::*;

    logic [STATE_W-1:0] ext;
    logic [STATE_W-1:0] mixed;
    logic [STATE_W-1:0] lcg_in;
    logic [STATE_W-1:0] lcg_out;
    logic [7:0]         keystream;

    // sign extension for passphrase bytes, zero extension for salt bytes
    assign ext = (op == OP_PASS) ? {{(STATE_W-8){byte_in[7]}}, byte_in}
                                 : {{(STATE_W-8){1'b0}}, byte_in};
    assign mixed = ext << lcg_state[3:0];
    assign lcg_in = (op == OP_DATA) ? lcg_state : (lcg_state ^ mixed);
    assign lcg_out = STATE_W'(lcg_in * LCG_MUL + LCG_ADD);
    assign keystream = key_seen ? lcg_out[23:16] : 8'h00;

    always_comb begin
        step = '0;
        unique case (op)
            OP_START: begin
                step.lcg_state  = LCG_SEED;
                step.key_seen   = 1'b0;
                step.has_result = 1'b0;
            end
            OP_PASS: begin
                step.lcg_state  = lcg_out;
                step.key_seen   = 1'b1;
                step.has_result = 1'b0;
            end
            OP_SALT: begin
                step.lcg_state  = lcg_out;
                step.key_seen   = key_seen;
                step.has_result = 1'b0;
            end
            OP_DATA: begin
                step.lcg_state  = lcg_out;
                step.key_seen   = key_seen;
                step.has_result = 1'b1;
                step.byte_out   = byte_in ^ keystream;
            end
            default: begin
                step.lcg_state  = lcg_state;
                step.key_seen   = key_seen;
            end
        endcase
    end

endmodule

FILE: hw/rtl/lcg_keystream_xor_cipher.sv
// top level of the lcg keystream xor cipher
// Byte stream cipher over a 31-bit linear congruential generator. Each request
// carries an op (start, passphrase byte, salt byte, data byte) and a byte; only
// data bytes return a result, the byte xored with generator state bits 23..16,
// or unchanged while no passphrase byte has been seen since the last start.
// A request is registered on acceptance and retired when the generator step
// (one constant multiply and add) updates the state and, for a data byte,
// loads the output register; a data byte waits while that register holds an
// untaken result. One request is accepted every cycle while the output is not
// stalled, and the state feedback through the multiplier allows one byte per
// cycle. Encryption and decryption are the same operation.
module lcg_keystream_xor_cipher (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [7:0] s_byte_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_byte_out
);
    import lcgx_pkg::*;

    logic               in_valid_reg;
    op_t                in_op_reg;
    logic [7:0]         in_byte_reg;
    logic [STATE_W-1:0] lcg_state_reg;
    logic               key_seen_reg;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_valid_next;
    logic               advance;
    logic               out_free;
    step_t              step;

    lcgx_step u_step (
        .op        (in_op_reg),
        .byte_in   (in_byte_reg),
        .lcg_state (lcg_state_reg),
        .key_seen  (key_seen_reg),
        .step      (step)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!step.has_result || out_free);
    assign s_ready  = !in_valid_reg || advance;

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (advance && step.has_result) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lcg_state_reg <= LCG_SEED;
            key_seen_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance) begin
                lcg_state_reg <= step.lcg_state;
                key_seen_reg  <= step.key_seen;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= op_t'(s_op);
            in_byte_reg <= s_byte_in;
        end
        if (advance && step.has_result) begin
            out_byte_reg <= step.byte_out;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_byte_out = out_byte_reg;

`ifndef ASSERT_OFF
    a_start_reseeds: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == OP_START) |=>
            (lcg_state_reg == LCG_SEED && !key_seen_reg))
        else $error("start request did not reseed the generator");

    a_pass_sets_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == OP_PASS) |=> key_seen_reg)
        else $error("passphrase request did not set key seen");

    a_data_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == OP_DATA) |=> out_valid_reg)
        else $error("data request retired without a result");

    a_held_request_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_op_reg)
            && $stable(in_byte_reg)))
        else $error("stalled request was lost or changed");

    a_state_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(lcg_state_reg) && $stable(key_seen_reg)))
        else $error("generator state moved without a retired request");
`endif

endmodule

FILE: sim/lcgx_scoreboard.sv
// scoreboard that predicts the cipher output bytes and compares them with the block
module lcgx_scoreboard (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [7:0] s_byte_in,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_byte_out,
    output int         mismatch_count,
    output int         bytes_pending
);
    import lcgx_pkg::*;

    localparam logic [30:0] SEED = 31'h12345678;
    localparam logic [30:0] MULT = 31'd1103515245;
    localparam logic [30:0] INCR = 31'd12345;

    logic [30:0] gen_state;
    logic        key_seen;
    logic [7:0]  cipher_bytes_q[$];
    int          fails = 0;
    int          pending = 0;

    assign mismatch_count = fails;
    assign bytes_pending  = pending;

    function automatic logic [30:0] lcg_next(input logic [30:0] s);
        logic [30:0] r;
        r = s * MULT + INCR;
        return r;
    endfunction

    // xor the extended byte in at the offset picked by the low state bits, then step
    function automatic logic [30:0] absorb(input logic [30:0] s, input logic [31:0] ext);
        logic [31:0] mixed;
        mixed = ext << s[3:0];
        return lcg_next(s ^ mixed[30:0]);
    endfunction

    task automatic report_mismatch(input string msg);
        if (fails < 64) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        fails++;
    endtask

    always @(posedge aclk) begin : watch
        logic [7:0] want;
        if (!aresetn) begin
            gen_state = SEED;
            key_seen  = 1'b0;
            cipher_bytes_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                case (op_t'(s_op))
                    OP_START: begin
                        gen_state = SEED;
                        key_seen  = 1'b0;
                    end
                    OP_PASS: begin
                        gen_state = absorb(gen_state, {{24{s_byte_in[7]}}, s_byte_in});
                        key_seen  = 1'b1;
                    end
                    OP_SALT: begin
                        gen_state = absorb(gen_state, {24'd0, s_byte_in});
                    end
                    default: begin
                        gen_state = lcg_next(gen_state);
                        cipher_bytes_q.push_back(s_byte_in ^
                                                 (key_seen ? gen_state[23:16] : 8'h00));
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (cipher_bytes_q.size() == 0) begin
                    report_mismatch($sformatf("byte_out %02h with no request waiting",
                                              m_byte_out));
                end else begin
                    want = cipher_bytes_q.pop_front();
                    if (m_byte_out !== want) begin
                        report_mismatch($sformatf("byte_out %02h, expected %02h",
                                                  m_byte_out, want));
                    end
                end
            end
        end
        pending <= cipher_bytes_q.size();
    end

endmodule

FILE: sim/tb_lcg_keystream_xor_cipher.sv
// testbench top for the lcg keystream xor cipher: stimulus, flow control and verdict
module tb_lcg_keystream_xor_cipher;
    import lcgx_pkg::*;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_op = OP_START;
    logic [7:0] s_byte_in = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_byte_out;
    int         mismatch_count;
    int         bytes_pending;
    bit         idle_on = 1'b1;
    int         requests_sent = 0;
    int         bytes_taken = 0;

    always #5 aclk = ~aclk;

    lcg_keystream_xor_cipher dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_byte_in  (s_byte_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_byte_out (m_byte_out)
    );

    lcgx_scoreboard scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_byte_in      (s_byte_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_out     (m_byte_out),
        .mismatch_count (mismatch_count),
        .bytes_pending  (bytes_pending)
    );

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic push_request(input op_t op, input logic [7:0] b);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_byte_in <= b;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    // result side; long hold-offs let the block fill up and stall its input
    initial begin : drain
        int unsigned pause;
        @(posedge aclk);
        forever begin
            pause = idle_on ? $urandom_range(0, 10) : 0;
            if (bytes_taken == 60 || bytes_taken == 400) begin
                pause = 300;
            end
            if (pause != 0) begin
                m_ready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            bytes_taken++;
        end
    end

    initial begin : stimulus
        int unsigned n_pass;
        int unsigned n_salt;
        int unsigned n_data;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // no passphrase yet, bytes pass through
        push_request(OP_DATA, 8'h00);
        push_request(OP_DATA, 8'hff);
        push_request(OP_START, 8'h00);
        push_request(OP_PASS, 8'h80);
        push_request(OP_PASS, 8'h7f);
        push_request(OP_PASS, 8'hff);
        push_request(OP_PASS, 8'h00);
        push_request(OP_SALT, 8'hff);
        push_request(OP_SALT, 8'h80);
        push_request(OP_SALT, 8'h00);
        push_request(OP_DATA, 8'h00);
        push_request(OP_DATA, 8'hff);
        push_request(OP_DATA, 8'ha5);
        push_request(OP_DATA, 8'h5a);
        // start ignores its byte and clears the key
        push_request(OP_START, 8'hff);
        push_request(OP_DATA, 8'h3c);
        // salt ahead of passphrase, absorb after data
        push_request(OP_SALT, 8'h12);
        push_request(OP_PASS, 8'h34);
        push_request(OP_DATA, 8'h55);
        push_request(OP_PASS, 8'h99);
        push_request(OP_DATA, 8'haa);
        push_request(OP_START, 8'h00);
        push_request(OP_DATA, 8'h01);

        while (requests_sent < 800) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    push_request(op_t'($urandom_range(0, 3)), 8'($urandom));
                end
            end else begin
                n_pass = $urandom_range(0, 8);
                n_salt = $urandom_range(0, 4);
                n_data = $urandom_range(1, 20);
                push_request(OP_START, 8'($urandom));
                repeat (n_pass) push_request(OP_PASS, 8'($urandom));
                repeat (n_salt) push_request(OP_SALT, 8'($urandom));
                repeat (n_data) push_request(OP_DATA, 8'($urandom));
            end
        end
        s_valid <= 1'b0;
        idle_on = 1'b1;

        @(posedge aclk);
        while (bytes_pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
